// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rhrs_pkg.sv -----
`timescale 1ns / 1ps
package rhrs_pkg;

  localparam int unsigned SlotsDef     = 8;
  localparam int unsigned WaitDepthDef = 16;
  localparam int unsigned MaxResults   = 8;
  localparam int unsigned ReadFactor   = 2;

  localparam logic FuncTick    = 1'b0;
  localparam logic FuncArrive  = 1'b1;
  localparam logic KindDone    = 1'b0;
  localparam logic KindReject  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] req_id;
    logic        is_write;
    logic [31:0] address;
    logic [15:0] length;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] done_id;
    logic        done_write;
    logic [31:0] latency;
    logic        last;
  } out_beat_t;

  typedef enum logic [3:0] {
    StIdle,
    StArrScan,
    StArrDecide,
    StTickScan,
    StEmit,
    StDrainRead,
    StDrainScan,
    StDrainDecide,
    StWaitOut
  } state_e;

endpackage

// ----- rtl/rhrs_overlap.sv -----
`timescale 1ns / 1ps
// one range overlap compare, shared by every hazard scan
module rhrs_overlap (
  input  logic [31:0] a_addr_i,
  input  logic [15:0] a_len_i,
  input  logic [31:0] b_addr_i,
  input  logic [15:0] b_len_i,
  output logic        hit_o
);
  logic [32:0] a_end, b_end;
  assign a_end = {1'b0, a_addr_i} + {17'd0, a_len_i};
  assign b_end = {1'b0, b_addr_i} + {17'd0, b_len_i};
  assign hit_o = ({1'b0, a_addr_i} < b_end) && ({1'b0, b_addr_i} < a_end);
endmodule

// ----- rtl/range_hazard_request_scheduler_top.sv -----
`timescale 1ns / 1ps
// an arrival scans every slot, then is started or queued in the decide state; a reject goes
// on through the emit state to the output register; a tick walks the slots for a due one
// each completion retires its slot, then rescans the slots for each fifo head tried
// throughput: one beat at a time, set by the single overlap comparator walking the slots;
// results also wait while the output register is held by out_ready_i
// reset: asynchronous active low; time, valid bits, fifo pointers cleared, max_active = 1
`include "assert_macros.svh"
module range_hazard_request_scheduler_top #(
  parameter int unsigned SLOTS      = rhrs_pkg::SlotsDef,
  parameter int unsigned WAIT_DEPTH = rhrs_pkg::WaitDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhrs_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rhrs_pkg::out_beat_t out_data_o
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned NW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned LimCap = (SLOTS < rhrs_pkg::MaxResults) ? SLOTS
                                                                  : rhrs_pkg::MaxResults;
  localparam logic [WW:0] WaitDepthW = WAIT_DEPTH[WW:0];

  // configuration and time
  logic [3:0]  max_active_q;
  logic [31:0] time_q, time_d;

  // slot storage, valid bits in flops
  logic [SLOTS-1:0] sv_q, sv_d;
  logic [15:0] s_id   [SLOTS];
  logic [31:0] s_addr [SLOTS];
  logic [15:0] s_len  [SLOTS];
  logic        s_wr   [SLOTS];
  logic [31:0] s_arr  [SLOTS];
  logic [31:0] s_fin  [SLOTS];

  // fifo memory
  logic [15:0] w_id   [WAIT_DEPTH];
  logic        w_wr   [WAIT_DEPTH];
  logic [31:0] w_addr [WAIT_DEPTH];
  logic [15:0] w_len  [WAIT_DEPTH];
  logic [31:0] w_arr  [WAIT_DEPTH];
  logic [WW-1:0] head_q, head_d;
  logic [NW-1:0] cnt_q, cnt_d;

  // candidate request under test (arrival or fifo head)
  logic [15:0] c_id_q;
  logic        c_wr_q;
  logic [31:0] c_addr_q, c_arr_q;
  logic [15:0] c_len_q;

  rhrs_pkg::state_e st_q, st_d;
  logic [SW-1:0] idx_q, idx_d;        // scan pointer
  logic [SW-1:0] tick_idx_q, tick_idx_d; // completion walk pointer
  logic          hz_q, hz_d;
  logic [CW-1:0] act_q, act_d;        // active count, built during the scan
  logic          free_ok_q, free_ok_d;
  logic [SW-1:0] free_q, free_d;      // lowest free slot
  logic [3:0]    nres_q, nres_d;
  logic          pend_q, pend_d;      // a result is held for emission
  rhrs_pkg::out_beat_t res_q, res_d;
  logic          out_v_q, out_v_d;
  rhrs_pkg::out_beat_t out_q, out_d;
  logic          tick_more_q, tick_more_d;

  // datapath controls
  logic do_start, do_push, do_retire, do_pop, load_head;
  logic [SW-1:0] retire_idx;

  logic hit;
  rhrs_overlap u_ovl (
    .a_addr_i (s_addr[idx_q]),
    .a_len_i  (s_len[idx_q]),
    .b_addr_i (c_addr_q),
    .b_len_i  (c_len_q),
    .hit_o    (hit)
  );

  logic [3:0] lim;
  assign lim = (max_active_q > 4'(LimCap)) ? 4'(LimCap) : max_active_q;

  logic fits;
  assign fits = ({{(32-CW){1'b0}}, act_q} < {28'd0, lim}) && !hz_q && free_ok_q;

  // fifo tail, wrapped by compare and subtract
  logic [WW:0]   tail_sum;
  logic [WW-1:0] tail;
  assign tail_sum = {1'b0, head_q} + {1'b0, cnt_q[WW-1:0]};
  assign tail = (tail_sum >= WaitDepthW) ? WW'(tail_sum - WaitDepthW) : tail_sum[WW-1:0];

  logic [WW:0] head_inc;
  assign head_inc = {1'b0, head_q} + {{WW{1'b0}}, 1'b1};

  logic last_idx;
  assign last_idx = (idx_q == SW'(SLOTS - 1));

  // next-state logic
  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    tick_idx_d  = tick_idx_q;
    hz_d        = hz_q;
    act_d       = act_q;
    free_ok_d   = free_ok_q;
    free_d      = free_q;
    nres_d      = nres_q;
    pend_d      = pend_q;
    res_d       = res_q;
    time_d      = time_q;
    tick_more_d = tick_more_q;
    load_head   = 1'b0;
    case (st_q)
      rhrs_pkg::StIdle: begin
        if (in_valid_i) begin
          idx_d = '0; hz_d = 1'b0; act_d = '0; free_ok_d = 1'b0; nres_d = '0;
          if (in_data_i.func == rhrs_pkg::FuncArrive) st_d = rhrs_pkg::StArrScan;
          else begin
            time_d = time_q + 32'd1;
            tick_idx_d = '0;
            st_d = rhrs_pkg::StTickScan;
          end
        end
      end
      rhrs_pkg::StArrScan, rhrs_pkg::StDrainScan: begin
        if (sv_q[idx_q]) begin
          act_d = act_q + CW'(1);
          if (s_wr[idx_q] && hit) hz_d = 1'b1;
        end else if (!free_ok_q) begin
          free_ok_d = 1'b1; free_d = idx_q;
        end
        if (last_idx) st_d = (st_q == rhrs_pkg::StArrScan) ? rhrs_pkg::StArrDecide
                                                          : rhrs_pkg::StDrainDecide;
        else idx_d = idx_q + SW'(1);
      end
      rhrs_pkg::StArrDecide: begin
        if (!fits && cnt_q == NW'(WAIT_DEPTH)) begin
          res_d = '{kind: rhrs_pkg::KindReject, done_id: c_id_q, done_write: c_wr_q,
                    latency: 32'd0, last: 1'b1};
          pend_d = 1'b1; tick_more_d = 1'b0;
          st_d = rhrs_pkg::StEmit;
        end else st_d = rhrs_pkg::StIdle;
      end
      rhrs_pkg::StTickScan: begin
        // one slot per cycle, stop at a due one
        if (sv_q[tick_idx_q] && s_fin[tick_idx_q] == time_q
            && nres_q < 4'(rhrs_pkg::MaxResults)) begin
          res_d = '{kind: rhrs_pkg::KindDone, done_id: s_id[tick_idx_q],
                    done_write: s_wr[tick_idx_q],
                    latency: time_q - s_arr[tick_idx_q],
                    last: (tick_idx_q == SW'(SLOTS - 1))};
          pend_d = 1'b1;
          nres_d = nres_q + 4'd1;
          tick_more_d = (tick_idx_q != SW'(SLOTS - 1));
          st_d = rhrs_pkg::StDrainRead;
        end else if (tick_idx_q == SW'(SLOTS - 1)) begin
          if (pend_q) begin
            res_d.last = 1'b1; tick_more_d = 1'b0; st_d = rhrs_pkg::StEmit;
          end else st_d = rhrs_pkg::StIdle;
        end else tick_idx_d = tick_idx_q + SW'(1);
      end
      rhrs_pkg::StDrainRead: begin
        // retire happened; try the fifo head
        if (cnt_q != '0) begin
          load_head = 1'b1;
          idx_d = '0; hz_d = 1'b0; act_d = '0; free_ok_d = 1'b0;
          st_d = rhrs_pkg::StDrainScan;
        end else st_d = rhrs_pkg::StEmit;
      end
      rhrs_pkg::StDrainDecide: begin
        if (fits && cnt_q != '0) begin
          load_head = 1'b1;
          idx_d = '0; hz_d = 1'b0; act_d = '0; free_ok_d = 1'b0;
          st_d = (cnt_q == NW'(1)) ? rhrs_pkg::StEmit : rhrs_pkg::StDrainScan;
        end else st_d = rhrs_pkg::StEmit;
      end
      rhrs_pkg::StEmit: begin
        // hold one completion until the next due slot is known, so last is right
        if (!tick_more_q) begin
          if (!out_v_q || out_ready_i) begin
            pend_d = 1'b0;
            st_d = rhrs_pkg::StIdle;
          end
        end else st_d = rhrs_pkg::StWaitOut;
      end
      rhrs_pkg::StWaitOut: begin
        // look ahead for another due slot before releasing the held result
        if (tick_idx_q == SW'(SLOTS - 1)) begin
          res_d.last = 1'b1; tick_more_d = 1'b0; st_d = rhrs_pkg::StEmit;
        end else begin
          tick_idx_d = tick_idx_q + SW'(1);
          if (sv_q[tick_idx_q + SW'(1)] && s_fin[tick_idx_q + SW'(1)] == time_q
              && nres_q < 4'(rhrs_pkg::MaxResults)) begin
            if (!out_v_q || out_ready_i) begin
              pend_d = 1'b0;
              st_d = rhrs_pkg::StTickScan;
            end else tick_idx_d = tick_idx_q;
          end
        end
      end
      default: st_d = rhrs_pkg::StIdle;
    endcase
  end

  // output logic
  always_comb begin
    do_start   = 1'b0;
    do_push    = 1'b0;
    do_retire  = 1'b0;
    do_pop     = 1'b0;
    retire_idx = tick_idx_q;
    out_v_d    = out_v_q;
    out_d      = out_q;
    in_ready_o = (st_q == rhrs_pkg::StIdle);
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    case (st_q)
      rhrs_pkg::StArrDecide: begin
        if (fits) do_start = 1'b1;
        else if (cnt_q != NW'(WAIT_DEPTH)) do_push = 1'b1;
      end
      rhrs_pkg::StTickScan: begin
        if (sv_q[tick_idx_q] && s_fin[tick_idx_q] == time_q
            && nres_q < 4'(rhrs_pkg::MaxResults)) do_retire = 1'b1;
      end
      rhrs_pkg::StDrainDecide: begin
        if (fits && cnt_q != '0) begin
          do_start = 1'b1; do_pop = 1'b1;
        end
      end
      rhrs_pkg::StEmit: begin
        if (!tick_more_q && (!out_v_q || out_ready_i)) begin
          out_v_d = 1'b1; out_d = res_q;
        end
      end
      rhrs_pkg::StWaitOut: begin
        if (tick_idx_q != SW'(SLOTS - 1)
            && sv_q[tick_idx_q + SW'(1)] && s_fin[tick_idx_q + SW'(1)] == time_q
            && nres_q < 4'(rhrs_pkg::MaxResults) && (!out_v_q || out_ready_i)) begin
          out_v_d = 1'b1; out_d = res_q;
        end
      end
      default: ;
    endcase
  end

  // fifo and slot bookkeeping
  always_comb begin
    sv_d   = sv_q;
    head_d = head_q;
    cnt_d  = cnt_q;
    if (do_retire) sv_d[retire_idx] = 1'b0;
    if (do_start) sv_d[free_q] = 1'b1;
    if (do_push) cnt_d = cnt_q + NW'(1);
    if (do_pop) begin
      head_d = (head_inc >= WaitDepthW) ? '0 : head_inc[WW-1:0];
      cnt_d  = cnt_q - NW'(1);
    end
  end

  logic [31:0] svc;
  always_comb begin
    svc = (c_len_q == '0) ? 32'd1 : {16'd0, c_len_q};
    if (!c_wr_q) svc = svc * rhrs_pkg::ReadFactor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_active_q <= 4'd1;
      time_q       <= '0;
      sv_q         <= '0;
      head_q       <= '0;
      cnt_q        <= '0;
      st_q         <= rhrs_pkg::StIdle;
      idx_q        <= '0;
      tick_idx_q   <= '0;
      hz_q         <= 1'b0;
      act_q        <= '0;
      free_ok_q    <= 1'b0;
      free_q       <= '0;
      nres_q       <= '0;
      pend_q       <= 1'b0;
      out_v_q      <= 1'b0;
      tick_more_q  <= 1'b0;
    end else begin
      if (cfg_we_i) max_active_q <= cfg_wdata_i;
      time_q      <= time_d;
      sv_q        <= sv_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      st_q        <= st_d;
      idx_q       <= idx_d;
      tick_idx_q  <= tick_idx_d;
      hz_q        <= hz_d;
      act_q       <= act_d;
      free_ok_q   <= free_ok_d;
      free_q      <= free_d;
      nres_q      <= nres_d;
      pend_q      <= pend_d;
      out_v_q     <= out_v_d;
      tick_more_q <= tick_more_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    if (st_q == rhrs_pkg::StIdle && in_valid_i) begin
      c_id_q   <= in_data_i.req_id;
      c_wr_q   <= in_data_i.is_write;
      c_addr_q <= in_data_i.address;
      c_len_q  <= in_data_i.length;
      c_arr_q  <= time_q;
    end else if (load_head) begin
      c_id_q   <= w_id[head_d];
      c_wr_q   <= w_wr[head_d];
      c_addr_q <= w_addr[head_d];
      c_len_q  <= w_len[head_d];
      c_arr_q  <= w_arr[head_d];
    end
    if (do_start) begin
      s_id[free_q]   <= c_id_q;
      s_wr[free_q]   <= c_wr_q;
      s_addr[free_q] <= c_addr_q;
      s_len[free_q]  <= c_len_q;
      s_arr[free_q]  <= c_arr_q;
      s_fin[free_q]  <= time_q + svc;
    end
    if (do_push) begin
      w_id[tail]   <= c_id_q;
      w_wr[tail]   <= c_wr_q;
      w_addr[tail] <= c_addr_q;
      w_len[tail]  <= c_len_q;
      w_arr[tail]  <= c_arr_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= NW'(WAIT_DEPTH), "fifo count overflow")
  `ASSERT_IMPLY(a_no_start_full, clk_i, rst_ni, do_start, !sv_q[free_q], "start into busy slot")
  `ASSERT_IMPLY(a_push_room, clk_i, rst_ni, do_push, cnt_q != NW'(WAIT_DEPTH), "push when full")
  `ASSERT_IMPLY(a_busy_ready, clk_i, rst_ni, st_q != rhrs_pkg::StIdle, !in_ready_o,
                "ready while busy")
endmodule
